>>> hw/rtl/upd_pkg.sv
// Package for the URL percent decoder: state and result types, character
// codes and the per-byte decode functions. No dependencies.
`default_nettype none

package upd_pkg;

  localparam int HOST_PREFIX_LIMIT = 16;
  localparam int POS_W = $clog2(HOST_PREFIX_LIMIT + 2);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(HOST_PREFIX_LIMIT);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  typedef struct packed {
    logic [1:0]       held_count;
    logic [7:0]       held_digit;
    logic             stopped;
    logic [POS_W-1:0] pos;
    logic [7:0]       prev;
  } upd_state_t;

  // Results of one input transaction, slot 0 delivered first.
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
    logic            last;
  } upd_res_t;

  typedef struct packed {
    upd_state_t      st;
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
  } upd_work_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  function automatic upd_work_t push(upd_work_t w, logic [7:0] c);
    upd_work_t r;
    r = w;
    if (w.n != 2'd3) begin
      r.bytes[w.n] = c;
      r.n = w.n + 2'd1;
    end
    return r;
  endfunction

  function automatic upd_work_t emit_decoded(upd_work_t w, logic [7:0] c, logic mode);
    upd_work_t r;
    logic [7:0] prev;
    logic [POS_W-1:0] pos;
    r = push(w, c);
    prev = w.st.prev;
    if (w.st.pos <= POS_LIMIT) r.st.pos = w.st.pos + POS_W'(1);
    pos = r.st.pos;
    r.st.prev = c;
    if (mode) begin
      if (c == CH_QMARK || c == CH_HASH || c == CH_SOH) begin
        r.st.stopped = 1'b1;
      end else if (c == CH_SLASH) begin
        if (pos == POS_FIRST || pos > POS_LIMIT ||
            (prev != CH_COLON && prev != CH_SLASH)) r.st.stopped = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic upd_work_t fresh_byte(upd_work_t w, logic [7:0] b, logic mode);
    upd_work_t r;
    logic [7:0] c;
    r = w;
    c = b;
    if (mode && w.st.stopped) begin
      r = push(w, b);
    end else if (b == CH_PCT) begin
      r.st.held_count = HELD_PCT;
    end else begin
      if (b == CH_PLUS || b == CH_NUL) c = CH_SPACE;
      r = emit_decoded(w, c, mode);
    end
    return r;
  endfunction

  function automatic upd_work_t take_byte(upd_work_t w, logic [7:0] b, logic mode);
    upd_work_t r;
    logic [7:0] c;
    r = w;
    c = {hex_val(w.st.held_digit), hex_val(b)};
    if (c == CH_NUL) c = CH_SPACE;
    if (w.st.held_count == HELD_PCT) begin
      if (is_hex(b)) begin
        r.st.held_digit = b;
        r.st.held_count = HELD_DIGIT;
      end else begin
        r.st.held_count = HELD_NONE;
        r = emit_decoded(r, CH_PCT, mode);
        r = fresh_byte(r, b, mode);
      end
    end else if (w.st.held_count == HELD_DIGIT) begin
      r.st.held_count = HELD_NONE;
      if (is_hex(b)) begin
        r = emit_decoded(r, c, mode);
      end else begin
        r = emit_decoded(r, CH_PCT, mode);
        r = fresh_byte(r, w.st.held_digit, mode);
        r = fresh_byte(r, b, mode);
      end
    end else begin
      r.st.held_count = HELD_NONE;
      r = fresh_byte(r, b, mode);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/url_percent_decoder.sv
// URL percent decoder top level: configuration register, decode stage and
// result queue. Depends on upd_pkg, upd_decode and upd_outq.
//
// Usage: encoded URL bytes enter on the in_ stream, one byte per
// transaction, with in_tlast on the final byte of a string. Decoded bytes
// leave on the out_ stream; out_tlast marks the final byte of the string and
// out_tuser the last byte caused by one input transaction. An input byte
// produces zero to three output bytes.
// cfg_wr_en writes host_only_mode from cfg_wr_data. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Throughput is one input byte per cycle while each byte yields at most one
// result and the receiver is ready; a byte with more results holds in_tready
// low until the single output register takes its last result from the queue.
// Synchronous reset clears the mode, per-string state, queue and output valid.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_tready drops until the queue drains.
`default_nettype none

module url_percent_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // out_string_end
  output logic            out_tuser,  // out_run_end
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data // host_only_mode
);

  logic              mode_r;
  logic              accept;
  upd_pkg::upd_res_t res;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  upd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .mode    (mode_r),
    .res     (res)
  );

  upd_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (accept),
    .res            (res),
    .ready          (in_tready),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_string_end (out_tlast),
    .out_run_end    (out_tuser)
  );

endmodule

`default_nettype wire

>>> hw/rtl/upd_decode.sv
// Decode stage: per-string state registers and the single-pass logic that
// turns one input byte into zero to three result bytes. Uses upd_pkg.
`default_nettype none

module upd_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  input  wire logic            mode,
  output upd_pkg::upd_res_t    res
);

  upd_pkg::upd_state_t st_r;
  upd_pkg::upd_state_t st_nxt;
  upd_pkg::upd_work_t  w;
  logic [1:0]          flush_cnt;
  logic [7:0]          flush_digit;

  always_comb begin
    w.st    = st_r;
    w.n     = 2'd0;
    w.bytes = '0;
    w = upd_pkg::take_byte(w, in_byte, mode);
    flush_cnt   = w.st.held_count;
    flush_digit = w.st.held_digit;
    if (in_last) begin
      // End of string: anything still held goes out as literal text.
      if (flush_cnt != upd_pkg::HELD_NONE) begin
        w.st.held_count = upd_pkg::HELD_NONE;
        w = upd_pkg::emit_decoded(w, upd_pkg::CH_PCT, mode);
        if (flush_cnt == upd_pkg::HELD_DIGIT) w = upd_pkg::fresh_byte(w, flush_digit, mode);
      end
      w.st = '0;
    end
    st_nxt    = w.st;
    res.n     = w.n;
    res.bytes = w.bytes;
    res.last  = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/upd_outq.sv
// Result queue: holds the up to three bytes of one transaction and feeds them
// one per cycle into the output register while it is not stalled. Uses upd_pkg.
`default_nettype none

module upd_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire upd_pkg::upd_res_t res,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_string_end,
  output logic                   out_run_end
);

  logic [2:0][7:0] q_byte_r;
  logic [1:0]      q_cnt_r;
  logic            q_last_r;
  logic            ov_r;
  logic [7:0]      ob_r;
  logic            os_r;
  logic            or_r;
  logic            out_load;
  logic            pop_final;

  assign out_load  = (q_cnt_r != 2'd0) && (!ov_r || out_ready);
  assign pop_final = (q_cnt_r == 2'd1);
  // A new transaction may enter when the queue is empty or empties in this cycle.
  assign ready     = (q_cnt_r == 2'd0) || (pop_final && out_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      if (push && res.n != 2'd0) begin
        q_cnt_r <= res.n;
      end else if (out_load) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && res.n != 2'd0) begin
      q_byte_r <= res.bytes;
      q_last_r <= res.last;
    end else if (out_load) begin
      q_byte_r <= {8'h00, q_byte_r[2], q_byte_r[1]};
    end
    if (out_load) begin
      ob_r <= q_byte_r[0];
      or_r <= pop_final;
      os_r <= pop_final && q_last_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_string_end = os_r;
  assign out_run_end    = or_r;

endmodule

`default_nettype wire

>>> tb/upd_tb_pkg.sv
// Scoreboard for the URL percent decoder testbench: predicts the decoded
// bytes for each accepted input byte and checks the output stream against them.
// Depends on upd_pkg for character codes and the host prefix limit.
package upd_tb_pkg;

  import upd_pkg::*;

  class decode_scoreboard;

    typedef struct packed {
      logic [7:0] data;
      logic       str_end;
      logic       run_end;
    } decoded_t;

    decoded_t    decoded_q[$];
    logic [7:0]  step_bytes[$];
    int          mismatches;

    bit          host_mode;
    logic [1:0]  held;
    logic [7:0]  held_digit;
    bit          stopped;
    int unsigned out_pos;
    logic [7:0]  last_out;

    function new();
      host_mode  = 1'b0;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      held       = HELD_NONE;
      held_digit = 8'h00;
      stopped    = 1'b0;
      out_pos    = 0;
      last_out   = 8'h00;
    endfunction

    function void set_host_mode(bit m);
      host_mode = m;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // Returns the digit value, or -1 when the byte is not a hex digit.
    function int nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void put(logic [7:0] c);
      if (step_bytes.size() < 3) step_bytes.push_back(c);
    endfunction

    // A decoded byte advances the host prefix tracking and may end decoding.
    function void emit(logic [7:0] c);
      logic [7:0] prior;
      prior = last_out;
      put(c);
      if (out_pos <= HOST_PREFIX_LIMIT) out_pos++;
      last_out = c;
      if (host_mode) begin
        if (c == CH_QMARK || c == CH_HASH || c == CH_SOH) begin
          stopped = 1'b1;
        end else if (c == CH_SLASH) begin
          if (out_pos == 1 || out_pos > HOST_PREFIX_LIMIT ||
              (prior != CH_COLON && prior != CH_SLASH)) stopped = 1'b1;
        end
      end
    endfunction

    function void plain(logic [7:0] b);
      if (host_mode && stopped) begin
        put(b);
      end else if (b == CH_PCT) begin
        held = HELD_PCT;
      end else if (b == CH_PLUS || b == CH_NUL) begin
        emit(CH_SPACE);
      end else begin
        emit(b);
      end
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      int         lo;
      int         hi;
      logic [7:0] c;
      logic [7:0] d;
      logic [1:0] n;
      step_bytes.delete();
      case (held)
        HELD_PCT: begin
          if (nibble(b) >= 0) begin
            held_digit = b;
            held = HELD_DIGIT;
          end else begin
            held = HELD_NONE;
            emit(CH_PCT);
            plain(b);
          end
        end
        HELD_DIGIT: begin
          held = HELD_NONE;
          lo = nibble(b);
          if (lo >= 0) begin
            hi = nibble(held_digit);
            c = {hi[3:0], lo[3:0]};
            if (c == CH_NUL) c = CH_SPACE;
            emit(c);
          end else begin
            emit(CH_PCT);
            plain(held_digit);
            plain(b);
          end
        end
        default: begin
          held = HELD_NONE;
          plain(b);
        end
      endcase
      if (last) begin
        // A sequence left open at the end of the string is flushed literally.
        if (held != HELD_NONE) begin
          d = held_digit;
          n = held;
          held = HELD_NONE;
          emit(CH_PCT);
          if (n == HELD_DIGIT) plain(d);
        end
        clear_string();
      end
      foreach (step_bytes[k])
        decoded_q.push_back('{step_bytes[k], last && k == step_bytes.size() - 1,
                              k == step_bytes.size() - 1});
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_byte(logic [7:0] data, logic str_end, logic run_end);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        report($sformatf("output byte %02h with nothing expected", data));
      end else begin
        e = decoded_q.pop_front();
        if (data !== e.data)
          report($sformatf("byte %02h, expected %02h", data, e.data));
        if (str_end !== e.str_end)
          report($sformatf("tlast %b on byte %02h, expected %b", str_end, data, e.str_end));
        if (run_end !== e.run_end)
          report($sformatf("tuser %b on byte %02h, expected %b", run_end, data, e.run_end));
      end
    endtask

  endclass

endpackage

>>> tb/tb_url_percent_decoder.sv
// Testbench top for url_percent_decoder: directed and random URL strings in
// both decoding modes, with random stalls on both streams. Depends on
// upd_pkg and the scoreboard class in upd_tb_pkg.
module tb_url_percent_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;
  import upd_tb_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b1;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  decode_scoreboard sb;
  int items_sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit mode_now = 1'b0;

  url_percent_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #500us;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: ready drops in random bursts until the bench turns calm.
  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (rst_n && !calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    out_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, last);
    items_sent++;
    calm = (items_sent >= 160);
  endtask

  task automatic send_text(input string s, input bit end_string);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_string && i == s.len() - 1);
  endtask

  // The mode register is only written once the decoder has drained; a byte
  // that is merely held gives no result, so a short hold-off follows.
  task automatic write_mode(input bit m);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_host_mode(m);
    mode_now = m;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic send_random_string();
    logic [7:0] text[$];
    logic [7:0] c;
    string      alnum;
    int         len;
    int         kind;
    int         split;
    alnum = "abcdefghijklmnopqrstuvwxyz0123456789";
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 34) : $urandom_range(1, 14);
    // A scheme prefix lets host mode get past its first slashes.
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(0, 18)) text.push_back(8'(8'h61 + $urandom_range(0, 25)));
      text.push_back(CH_COLON);
      text.push_back(CH_SLASH);
      text.push_back(CH_SLASH);
    end
    while (text.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 26) begin
        if (kind < 18) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          case ($urandom_range(0, 5))
            0: c = CH_SLASH;
            1: c = CH_COLON;
            2: c = CH_QMARK;
            3: c = CH_HASH;
            4: c = CH_SOH;
            default: c = CH_NUL;
          endcase
        end
        text.push_back(CH_PCT);
        text.push_back(hex_char(c[7:4]));
        text.push_back(hex_char(c[3:0]));
      end else if (kind < 32) begin
        // A percent sign, with or without one hex digit; what comes next may complete or break it.
        text.push_back(CH_PCT);
        if ($urandom_range(0, 1)) text.push_back(hex_char(4'($urandom_range(0, 15))));
      end else if (kind < 42) begin
        text.push_back(CH_SLASH);
      end else if (kind < 47) begin
        text.push_back(CH_COLON);
      end else if (kind < 51) begin
        text.push_back(CH_PLUS);
      end else if (kind < 55) begin
        case ($urandom_range(0, 2))
          0: text.push_back(CH_QMARK);
          1: text.push_back(CH_HASH);
          default: text.push_back(CH_SOH);
        endcase
      end else if (kind < 58) begin
        text.push_back(CH_NUL);
      end else if (kind < 66) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        text.push_back(alnum[$urandom_range(0, 35)]);
      end
    end
    split = ($urandom_range(0, 7) == 0 && text.size() > 1) ?
            $urandom_range(1, text.size() - 1) : 0;
    for (int i = 0; i < text.size(); i++) begin
      if (i == split && i != 0) write_mode(!mode_now);
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Whole-string decoding: an escape with a lowercase digit, plus, zero and high
    // bytes, a decoded zero, a bad second character, and open escapes at
    // the end of a string.
    write_mode(1'b0);
    send_text("%4a+", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("%00%G", 1'b1);
    send_text("%4", 1'b1);
    send_text("%", 1'b1);

    // Host mode: a leading slash stops decoding at once, then a slash that
    // follows an ordinary byte.
    write_mode(1'b1);
    send_text("/%41", 1'b1);
    send_text("x://y/%41", 1'b1);

    while (items_sent < 185) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      send_random_string();
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> url_percent_decoder.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_decode.sv
hw/rtl/upd_outq.sv
hw/rtl/url_percent_decoder.sv
tb/upd_tb_pkg.sv
tb/tb_url_percent_decoder.sv
